/* sv/dtq_pkg.sv */
`default_nettype none

package dtq_pkg;

    // Slot count and field widths.
    localparam int NUM_TIMERS  = 16;
    localparam int ID_W        = 4;
    localparam int INC_W       = 31;
    localparam int TIME_W      = 64;
    localparam int LEFT_W      = 32;
    localparam int CNT_W       = 5;
    localparam int MAX_RESULTS = 16;
    localparam int S_TDATA_W   = 104;
    localparam int M_TDATA_W   = 40;

    // Request kinds.
    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_UPDATE = 2'd2,
        REQ_TICK   = 2'd3
    } req_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RUNNING  = 2'd1,
        ST_NOT_RUN  = 2'd2
    } status_t;

    // Back-end sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_CHECK_EMIT
    } state_t;

    // One classified command as it travels from front to back.
    typedef struct packed {
        req_t                req;
        logic [ID_W-1:0]     id;
        logic [INC_W-1:0]    inc;
        logic [TIME_W-1:0]   now;
    } cmd_t;

endpackage

`default_nettype wire

/* sv/deadline_timer_queue.sv */
// Channel  | Direction | Contents
// s_*      | in        | tuser: req_type[1:0]; tdata: timer_id, increment, now_ms
// m_*      | out       | tuser: status, expired_valid; tdata: expired_id, time_left; tlast
//
// Add, remove and update apply the command, scan the sixteen slots for the earliest
// deadline and then report. A tick reports each expiry only after the full scan of the
// sixteen slots that follows it, since each expiry is followed by a rescan.
// Reset clears every running mark; deadlines are not cleared.
// A two-entry queue takes new requests while results wait on m_tready.
`default_nettype none

module deadline_timer_queue
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // timer_id[3:0], increment[34:4], now_ms[98:35], zero pad
    input  wire logic [dtq_pkg::S_TDATA_W-1:0] s_tdata,
    // req_type[1:0]
    input  wire logic [1:0]                    s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // expired_id[3:0], time_left[35:4], zero pad
    output logic [dtq_pkg::M_TDATA_W-1:0]      m_tdata,
    // status[1:0], expired_valid[2]
    output logic [2:0]                         m_tuser,
    output logic                               m_tlast
);
    import dtq_pkg::*;

    logic q_valid;
    cmd_t q_cmd;
    logic q_pop;

    dtq_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop)
    );

    dtq_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // An expiry always reports a good status.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[2] |-> m_tuser[1:0] == ST_OK)
        else $error("expiry result with nonzero status");

    // A result without an expiry is the only result of its request.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[2] |-> m_tlast && m_tdata[3:0] == 4'd0)
        else $error("plain result not last or carries an id");

    // An error status comes only on a plain result, with a running or not-running code.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1:0] != ST_OK |->
            !m_tuser[2] && (m_tuser[1:0] == ST_RUNNING || m_tuser[1:0] == ST_NOT_RUN))
        else $error("bad status code");

endmodule

`default_nettype wire

/* sv/dtq_front.sv */
`default_nettype none

module dtq_front
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [dtq_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic [1:0]                    s_tuser,
    output logic                               q_valid,
    output dtq_pkg::cmd_t                      q_cmd,
    input  wire logic                          q_pop
);
    import dtq_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    cmd_t       in_cmd;
    logic       push;
    logic       pop;

    // Unpack and classify the incoming transaction.
    always_comb
    begin
        in_cmd.req = req_t'(s_tuser);
        in_cmd.id  = s_tdata[ID_W-1:0];
        in_cmd.inc = s_tdata[ID_W+INC_W-1:ID_W];
        in_cmd.now = s_tdata[ID_W+INC_W+TIME_W-1:ID_W+INC_W];
    end

    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && (count_reg != 2'd0);
    assign q_valid  = (count_reg != 2'd0);
    assign q_cmd    = entry_reg[rd_ptr_reg];

    // Queue pointers and fill count.
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

`default_nettype wire

/* sv/dtq_back.sv */
`default_nettype none

module dtq_back
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_valid,
    input  wire dtq_pkg::cmd_t                 q_cmd,
    output logic                               q_pop,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [dtq_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic [2:0]                         m_tuser,
    output logic                               m_tlast
);
    import dtq_pkg::*;

    state_t                  state_reg, state_next;
    cmd_t                    cmd_reg, cmd_next;
    logic [NUM_TIMERS-1:0]   running_reg, running_next;
    logic [TIME_W-1:0]       dl_reg [NUM_TIMERS];
    logic [ID_W-1:0]         idx_reg, idx_next;
    logic                    best_v_reg, best_v_next;
    logic [ID_W-1:0]         best_id_reg, best_id_next;
    logic [TIME_W-1:0]       best_dl_reg, best_dl_next;
    logic                    exp_v_reg, exp_v_next;
    logic [ID_W-1:0]         exp_id_reg, exp_id_next;
    logic [CNT_W-1:0]        n_reg, n_next;
    status_t                 status_reg, status_next;
    logic                    out_v_reg, out_v_next;
    logic [M_TDATA_W-1:0]    out_data_reg, out_data_next;
    logic [2:0]              out_user_reg, out_user_next;
    logic                    out_last_reg, out_last_next;
    logic                    dl_we;
    logic [TIME_W-1:0]       dl_wdata;
    logic                    is_tick;
    logic                    due;
    logic                    out_free;
    logic                    emit_last;
    logic [TIME_W-1:0]       diff;
    logic [LEFT_W-1:0]       time_left;

    assign is_tick  = (cmd_reg.req == REQ_TICK);
    assign due      = best_v_reg && (best_dl_reg <= cmd_reg.now);
    assign out_free = !out_v_reg || m_tready;
    assign emit_last = !is_tick || !exp_v_reg || !due || (n_reg == CNT_W'(MAX_RESULTS));

    // Time left to the earliest deadline, clamped and saturated.
    always_comb
    begin
        diff = best_dl_reg - cmd_reg.now;
        if (!best_v_reg)
        begin
            time_left = '1;
        end
        else if (cmd_reg.now > best_dl_reg)
        begin
            time_left = '0;
        end
        else if (diff[TIME_W-1:LEFT_W-1] != '0)
        begin
            time_left = {1'b0, {(LEFT_W-1){1'b1}}};
        end
        else
        begin
            time_left = diff[LEFT_W-1:0];
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (idx_reg == ID_W'(NUM_TIMERS - 1))
                begin
                    state_next = S_CHECK_EMIT;
                end
            end
            S_CHECK_EMIT:
            begin
                if (is_tick && !exp_v_reg && due)
                begin
                    state_next = S_SCAN;
                end
                else if (out_free)
                begin
                    state_next = emit_last ? S_IDLE : S_SCAN;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        q_pop         = 1'b0;
        cmd_next      = cmd_reg;
        running_next  = running_reg;
        dl_we         = 1'b0;
        dl_wdata      = cmd_reg.now + TIME_W'(cmd_reg.inc);
        idx_next      = idx_reg;
        best_v_next   = best_v_reg;
        best_id_next  = best_id_reg;
        best_dl_next  = best_dl_reg;
        exp_v_next    = exp_v_reg;
        exp_id_next   = exp_id_reg;
        n_next        = n_reg;
        status_next   = status_reg;
        out_v_next    = m_tready ? 1'b0 : out_v_reg;
        out_data_next = out_data_reg;
        out_user_next = out_user_reg;
        out_last_next = out_last_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    cmd_next = q_cmd;
                end
            end
            S_EXEC:
            begin
                // Apply the command, then start a scan.
                status_next = ST_OK;
                exp_v_next  = 1'b0;
                n_next      = '0;
                idx_next    = '0;
                best_v_next = 1'b0;
                case (cmd_reg.req)
                    REQ_ADD:
                    begin
                        if (running_reg[cmd_reg.id])
                        begin
                            status_next = ST_RUNNING;
                        end
                        else
                        begin
                            running_next[cmd_reg.id] = 1'b1;
                            dl_we = 1'b1;
                        end
                    end
                    REQ_REMOVE, REQ_UPDATE:
                    begin
                        if (!running_reg[cmd_reg.id])
                        begin
                            status_next = ST_NOT_RUN;
                        end
                        else if (cmd_reg.req == REQ_REMOVE)
                        begin
                            running_next[cmd_reg.id] = 1'b0;
                        end
                        else
                        begin
                            dl_we = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_SCAN:
            begin
                // One slot per cycle; strict compare keeps the lowest slot on ties.
                if (running_reg[idx_reg] && (!best_v_reg || dl_reg[idx_reg] < best_dl_reg))
                begin
                    best_v_next  = 1'b1;
                    best_id_next = idx_reg;
                    best_dl_next = dl_reg[idx_reg];
                end
                idx_next = idx_reg + 1'b1;
            end
            S_CHECK_EMIT:
            begin
                if (is_tick && !exp_v_reg && due)
                begin
                    // First expiry of this tick.
                    running_next[best_id_reg] = 1'b0;
                    exp_v_next  = 1'b1;
                    exp_id_next = best_id_reg;
                    n_next      = CNT_W'(1);
                    idx_next    = '0;
                    best_v_next = 1'b0;
                end
                else if (out_free)
                begin
                    out_v_next    = 1'b1;
                    out_data_next = {4'b0, time_left, exp_v_reg ? exp_id_reg : ID_W'(0)};
                    out_user_next = {exp_v_reg, status_reg};
                    out_last_next = emit_last;
                    if (!emit_last)
                    begin
                        // Expire the next due slot and rescan.
                        running_next[best_id_reg] = 1'b0;
                        exp_id_next = best_id_reg;
                        n_next      = n_reg + 1'b1;
                        idx_next    = '0;
                        best_v_next = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            running_reg <= '0;
            out_v_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            running_reg <= running_next;
            out_v_reg   <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        idx_reg      <= idx_next;
        best_v_reg   <= best_v_next;
        best_id_reg  <= best_id_next;
        best_dl_reg  <= best_dl_next;
        exp_v_reg    <= exp_v_next;
        exp_id_reg   <= exp_id_next;
        n_reg        <= n_next;
        status_reg   <= status_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
        out_last_reg <= out_last_next;
        if (dl_we)
        begin
            dl_reg[cmd_reg.id] <= dl_wdata;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

/* test/dtq_checker.sv */
`default_nettype none

module dtq_checker
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    input  wire logic                            s_tready,
    input  wire logic [dtq_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic [1:0]                      s_tuser,
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic [dtq_pkg::M_TDATA_W-1:0]   m_tdata,
    input  wire logic [2:0]                      m_tuser,
    input  wire logic                            m_tlast,
    output int                                   fail_count,
    output int                                   pending,
    output int                                   expiry_count
);
    import dtq_pkg::*;

    typedef struct packed {
        status_t            status;
        logic               exp_valid;
        logic [ID_W-1:0]    exp_id;
        logic [LEFT_W-1:0]  left;
        logic               last;
    } timer_result_t;

    // Private copy of the slot state.
    logic                running_q  [NUM_TIMERS];
    logic [TIME_W-1:0]   deadline_q [NUM_TIMERS];
    timer_result_t       expected_results[$];

    // Lowest slot holding the earliest running deadline, or -1.
    function automatic int earliest_running();
        int best;
        best = -1;
        for (int i = 0; i < NUM_TIMERS; i++)
            if (running_q[i] && (best < 0 || deadline_q[i] < deadline_q[best]))
                best = i;
        return best;
    endfunction

    function automatic logic [LEFT_W-1:0] time_left_at(logic [TIME_W-1:0] now);
        int e;
        logic [TIME_W-1:0] d;
        e = earliest_running();
        if (e < 0)
            return '1;
        if (now > deadline_q[e])
            return '0;
        d = deadline_q[e] - now;
        if (d > 64'h7FFF_FFFF)
            d = 64'h7FFF_FFFF;
        return d[LEFT_W-1:0];
    endfunction

    // Apply one accepted command to the private state and queue its results.
    task automatic predict_command(req_t req, logic [ID_W-1:0] id,
                                   logic [INC_W-1:0] inc, logic [TIME_W-1:0] now);
        timer_result_t r;
        int n;
        int e;
        n = 0;
        r = '0;
        if (req == REQ_TICK) begin
            while (n < MAX_RESULTS) begin
                e = earliest_running();
                if (e < 0 || deadline_q[e] > now)
                    break;
                running_q[e] = 1'b0;
                r.status    = ST_OK;
                r.exp_valid = 1'b1;
                r.exp_id    = e[ID_W-1:0];
                r.left      = time_left_at(now);
                r.last      = 1'b0;
                expected_results.push_back(r);
                expiry_count++;
                n++;
            end
            if (n == 0) begin
                r.left = time_left_at(now);
                r.last = 1'b1;
                expected_results.push_back(r);
            end else begin
                expected_results[$].last = 1'b1;
            end
        end else begin
            r.status = ST_OK;
            if (req == REQ_ADD) begin
                if (running_q[id]) begin
                    r.status = ST_RUNNING;
                end else begin
                    running_q[id]  = 1'b1;
                    deadline_q[id] = now + TIME_W'(inc);
                end
            end else if (!running_q[id]) begin
                r.status = ST_NOT_RUN;
            end else if (req == REQ_REMOVE) begin
                running_q[id] = 1'b0;
            end else begin
                deadline_q[id] = now + TIME_W'(inc);
            end
            r.left = time_left_at(now);
            r.last = 1'b1;
            expected_results.push_back(r);
        end
    endtask

    // Watch both channels at each rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        timer_result_t want;
        if (!rst_n) begin
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                running_q[i]  = 1'b0;
                deadline_q[i] = '0;
            end
            expected_results.delete();
            fail_count   = 0;
            expiry_count = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result transaction with no expectation waiting");
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_tuser[1:0] !== want.status) begin
                        $error("status expected %0d actual %0d", want.status, m_tuser[1:0]);
                        fail_count++;
                    end
                    if (m_tuser[2] !== want.exp_valid) begin
                        $error("expired_valid expected %0d actual %0d",
                               want.exp_valid, m_tuser[2]);
                        fail_count++;
                    end
                    if (m_tdata[3:0] !== want.exp_id) begin
                        $error("expired_id expected %0d actual %0d", want.exp_id, m_tdata[3:0]);
                        fail_count++;
                    end
                    if (m_tdata[35:4] !== want.left) begin
                        $error("time_left expected %0d actual %0d",
                               $signed(want.left), $signed(m_tdata[35:4]));
                        fail_count++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last expected %0d actual %0d", want.last, m_tlast);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict_command(req_t'(s_tuser), s_tdata[3:0], s_tdata[34:4], s_tdata[98:35]);
        end
        pending = expected_results.size();
    end

endmodule

`default_nettype wire

/* test/tb_deadline_timer_queue.sv */
`default_nettype none

module tb_deadline_timer_queue;
    import dtq_pkg::*;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    // timer_id[3:0], increment[34:4], now_ms[98:35], zero pad
    logic [S_TDATA_W-1:0]   s_tdata;
    // req_type[1:0]
    logic [1:0]             s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    // expired_id[3:0], time_left[35:4], zero pad
    logic [M_TDATA_W-1:0]   m_tdata;
    // status[1:0], expired_valid[2]
    logic [2:0]             m_tuser;
    logic                   m_tlast;

    int                     fail_count;
    int                     pending;
    int                     expiry_count;
    int                     send_idle_pct;
    int                     recv_idle_pct;
    int                     hold_cycles;
    int                     command_count;
    logic [TIME_W-1:0]      clock_ms;

    deadline_timer_queue dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    dtq_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .fail_count   (fail_count),
        .pending      (pending),
        .expiry_count (expiry_count)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Receiver: random backpressure, plus a long hold-off when requested.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready    <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offer one command and wait until it is accepted; valid stays high afterwards
    // so that back-to-back commands need no gap.
    task automatic send_command(req_t req, logic [ID_W-1:0] id,
                                logic [INC_W-1:0] inc, logic [TIME_W-1:0] now);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {5'b0, now, inc, id};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        command_count++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    // Random command mix; time mostly creeps forward so ticks expire slots.
    task automatic random_command();
        req_t               req;
        logic [INC_W-1:0]   inc;
        int                 pick;
        pick = $urandom_range(99);
        if (pick < 35)
            req = REQ_ADD;
        else if (pick < 50)
            req = REQ_REMOVE;
        else if (pick < 65)
            req = REQ_UPDATE;
        else
            req = REQ_TICK;
        pick = $urandom_range(9);
        if (pick < 6)
            inc = INC_W'($urandom_range(200));
        else if (pick < 9)
            inc = INC_W'($urandom >> 1);
        else
            inc = '1;
        clock_ms = clock_ms + TIME_W'($urandom_range(120));
        send_command(req, ID_W'($urandom_range(15)), inc, clock_ms);
    endtask

    initial begin : stimulus
        int i;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = REQ_ADD;
        hold_cycles   = 0;
        send_idle_pct = 31;
        recv_idle_pct = 77;
        command_count = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: misuse, extremes, wrap of deadline, ties, empty tick.
        send_command(REQ_TICK, 4'd0, '0, '0);
        send_command(REQ_REMOVE, 4'd3, '0, 64'd10);
        send_command(REQ_UPDATE, 4'd15, '1, 64'd10);
        send_command(REQ_ADD, 4'd0, 31'd100, 64'd0);
        send_command(REQ_ADD, 4'd0, 31'd5, 64'd1);
        send_command(REQ_ADD, 4'd15, '1, '1);
        send_command(REQ_ADD, 4'd7, 31'd100, 64'd0);
        send_command(REQ_ADD, 4'd9, '1, 64'h8000_0000_0000_0000);
        send_command(REQ_UPDATE, 4'd9, 31'd0, 64'd50);
        send_command(REQ_TICK, 4'd0, '0, 64'd49);
        send_command(REQ_TICK, 4'd0, '0, 64'd200);
        send_command(REQ_REMOVE, 4'd15, '0, 64'd200);
        send_command(REQ_ADD, 4'd15, 31'h5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        send_command(REQ_ADD, 4'd10, 31'h2AAA_AAAA, 64'h5555_5555_5555_5555);
        send_command(REQ_TICK, 4'd0, '0, '1);
        wait_drained();

        // Fill all sixteen slots and expire them in one tick.
        for (i = 0; i < NUM_TIMERS; i++)
            send_command(REQ_ADD, ID_W'(i), INC_W'(i % 3), 64'd1000);
        send_command(REQ_TICK, 4'd0, '0, 64'd1005);

        // Long receiver hold-off while commands keep arriving.
        hold_cycles = 400;
        clock_ms = 64'd2000;
        for (i = 0; i < 10; i++)
            random_command();
        wait_drained();

        for (i = 0; i < 20; i++)
            random_command();
        send_idle_pct = 77;
        recv_idle_pct = 31;
        for (i = 0; i < 20; i++)
            random_command();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (i = 0; i < 20; i++)
            random_command();
        send_command(REQ_TICK, 4'd0, '0, '1);

        wait_drained();
        $display("Covered %0d commands with %0d expiries, including misuse, wrap and stalls.",
                 command_count, expiry_count);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : watchdog
        #5000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
